FILE: rtl/core/mpbu_pkg.sv
package mpbu_pkg;

  localparam int unsigned NumTab = 14;
  localparam int unsigned DCells = 25;
  localparam int unsigned LCells = 40;

  typedef enum logic [2:0] {
    REG_PLAG,
    REG_LOW_BLEND,
    REG_SPINEL,
    REG_HIGH_BLEND,
    REG_GARNET
  } region_e;

  typedef struct packed {
    logic [3:0]         element;
    logic [15:0]        pressure_gpa;
    logic [15:0]        temperature;
    logic signed [15:0] melt_increment;
    logic [31:0]        solid_conc;
    logic               last_of_sweep;
  } in_word_t;

  typedef struct packed {
    logic [39:0] liquid_conc;
    logic [31:0] new_solid_conc;
    logic [23:0] partition_coef;
    logic [23:0] max_la_coef;
  } out_word_t;

  // per item data carried along the coefficient path
  typedef struct packed {
    logic [3:0]         element;
    logic signed [15:0] melt_increment;
    logic [31:0]        solid_conc;
    logic               last_of_sweep;
    logic               ok;
  } item_t;

  // per item data carried along the concentration path
  typedef struct packed {
    logic [31:0] solid_conc;
    logic [23:0] coef;
    logic [23:0] la_max;
    logic        ok;
    logic        ovf_liq;
    logic        ovf_sol;
  } tail_t;

  localparam int unsigned KOl  [NumTab] = '{50, 50, 80, 42, 110, 160, 110, 150, 270, 160,
                                            1300, 150, 2000, 2000};
  localparam int unsigned KOpx [NumTab] = '{310, 400, 480, 1200, 2000, 1300, 650, 1900,
                                            1100, 2600, 4500, 4000, 8000, 12000};
  localparam int unsigned KCpx [NumTab] = '{4900, 8000, 12600, 17800, 29300, 33500, 35000,
                                            40300, 40000, 42700, 42000, 40968, 40000, 37600};
  localparam int unsigned KPlg [NumTab] = '{27000, 20000, 17000, 14000, 11000, 73000, 6600,
                                            6000, 5500, 4800, 4100, 3600, 3100, 2500};
  localparam int unsigned KGrt [NumTab] = '{100, 500, 1400, 5200, 25000, 49600, 84800,
                                            147700, 220000, 331500, 440000, 549500, 660000,
                                            710000};

  function automatic logic [27:0] plag_sum(input logic [3:0] e);
    int unsigned s;
    s = 0;
    if (e < 4'(NumTab)) begin
      s = KOl[e] * 636 + KOpx[e] * 263 + KCpx[e] * 12 + KPlg[e] * 89;
    end
    return 28'(s);
  endfunction

  function automatic logic [27:0] spin_sum(input logic [3:0] e);
    int unsigned s;
    s = 0;
    if (e < 4'(NumTab)) begin
      s = KOl[e] * 578 + KOpx[e] * 270 + KCpx[e] * 119 + 1000 * 33;
    end
    return 28'(s);
  endfunction

  function automatic logic [27:0] garn_sum(input logic [3:0] e);
    int unsigned s;
    s = 0;
    if (e < 4'(NumTab)) begin
      s = KOl[e] * 598 + KOpx[e] * 211 + KCpx[e] * 79 + KGrt[e] * 115;
    end
    return 28'(s);
  endfunction

endpackage

FILE: rtl/core/mpbu_div_cell.sv
module mpbu_div_cell #(
  parameter int W  = 24,
  parameter int LW = 40,
  parameter int QW = 40
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  rem_i,
  input  logic [LW-1:0] low_i,
  input  logic [QW-1:0] quot_i,
  input  logic [W-1:0]  div_i,
  output logic [W-1:0]  rem_o,
  output logic [LW-1:0] low_o,
  output logic [QW-1:0] quot_o,
  output logic [W-1:0]  div_o
);

  logic [W:0]    cand;
  logic          ge;
  logic [W:0]    diff;
  logic [W-1:0]  rem_d;

  always_comb begin
    cand  = {rem_i, low_i[LW-1]};
    ge    = cand >= {1'b0, div_i};
    diff  = cand - {1'b0, div_i};
    rem_d = ge ? diff[W-1:0] : cand[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      low_o  <= low_i << 1;
      quot_o <= {quot_i[QW-2:0], ge};
      div_o  <= div_i;
    end
  end

endmodule

FILE: rtl/core/melt_partition_batch_update.sv
// channel   direction  payload                    handshake
// in        input      mpbu_pkg::in_word_t        in_valid_i / in_stall_o
// out       output     mpbu_pkg::out_word_t       out_valid_o / out_stall_i
//
// one word in and one word out per cycle while the output word is not stalled
// the pipeline runs through the 25 cell coefficient divider and the 40 cell quotient rows
// the whole pipeline holds while the output word is stalled, bubbles included
// reset clears the valid line and the la maximum; no other state
module melt_partition_batch_update #(
  parameter int NUM_ELEMENTS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpbu_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpbu_pkg::out_word_t out_word_o
);

  localparam int Depth = 4 + mpbu_pkg::DCells + 2 + mpbu_pkg::LCells + 1;
  localparam int DPos  = 3 + mpbu_pkg::DCells;

  logic [Depth-1:0] vld_q;
  logic             adv;

  assign adv         = ~vld_q[Depth-1] | ~out_stall_i;
  assign in_stall_o  = ~adv;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // input register
  mpbu_pkg::in_word_t in_q;
  always_ff @(posedge clk_i) begin
    if (adv) in_q <= in_word_i;
  end

  // facies sums, band edges and region
  logic [27:0]          fpl, fsp, fgt;
  logic [32:0]          pv, tsp, tgn, pvd;
  logic [22:0]          p100;
  logic signed [23:0]   pd;
  mpbu_pkg::region_e    region;
  logic signed [28:0]   a_d;
  logic signed [23:0]   b_d;
  logic [27:0]          base_d;
  logic [23:0]          scale_d;
  mpbu_pkg::item_t      item_d;

  always_comb begin
    fpl  = mpbu_pkg::plag_sum(in_q.element);
    fsp  = mpbu_pkg::spin_sum(in_q.element);
    fgt  = mpbu_pkg::garn_sum(in_q.element);
    pv   = 33'(in_q.pressure_gpa) * 33'd106672;
    tsp  = (33'(in_q.temperature) + 33'd6400) * 33'd40960;
    tgn  = (33'(in_q.temperature) + 33'd8528) * 33'd40960;
    pvd  = pv - tsp;
    p100 = 23'(in_q.pressure_gpa) * 23'd100;
    pd   = $signed({1'b0, p100}) - 24'sd462848;
    if (pv > tgn) region = mpbu_pkg::REG_GARNET;
    else if (pv > tsp) region = mpbu_pkg::REG_HIGH_BLEND;
    else if (p100 > 23'd462848) region = mpbu_pkg::REG_SPINEL;
    else if (p100 > 23'd331776) region = mpbu_pkg::REG_LOW_BLEND;
    else region = mpbu_pkg::REG_PLAG;
    a_d     = '0;
    b_d     = '0;
    base_d  = fpl;
    scale_d = 24'd8388608;
    unique case (region)
      mpbu_pkg::REG_GARNET: base_d = fgt;
      mpbu_pkg::REG_HIGH_BLEND: begin
        a_d     = $signed({1'b0, fgt}) - $signed({1'b0, fsp});
        b_d     = $signed({1'b0, pvd[26:4]});
        base_d  = fsp;
        scale_d = 24'd5447680;
      end
      mpbu_pkg::REG_SPINEL: base_d = fsp;
      mpbu_pkg::REG_LOW_BLEND: begin
        a_d     = $signed({1'b0, fsp}) - $signed({1'b0, fpl});
        b_d     = pd;
        base_d  = fpl;
        scale_d = 24'd131072;
      end
      default: base_d = fpl;
    endcase
    item_d.element        = in_q.element;
    item_d.melt_increment = in_q.melt_increment;
    item_d.solid_conc     = in_q.solid_conc;
    item_d.last_of_sweep  = in_q.last_of_sweep;
    item_d.ok = (in_q.melt_increment != 16'sd0) && !in_q.melt_increment[15]
                && (32'(in_q.element) < NUM_ELEMENTS);
  end

  logic signed [28:0] a_q;
  logic signed [23:0] b_q;
  logic [27:0]        base_q;
  logic [23:0]        scale_q;
  mpbu_pkg::region_e  region1_q;
  mpbu_pkg::item_t    item1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= a_d;
      b_q       <= b_d;
      base_q    <= base_d;
      scale_q   <= scale_d;
      region1_q <= region;
      item1_q   <= item_d;
    end
  end

  // products
  logic signed [52:0] prod_q;
  logic [51:0]        basep_q;
  mpbu_pkg::region_e  region2_q;
  mpbu_pkg::item_t    item2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= 53'(a_q) * 53'(b_q);
      basep_q   <= 52'(base_q) * 52'(scale_q);
      region2_q <= region1_q;
      item2_q   <= item1_q;
    end
  end

  // rounding dividend
  logic signed [53:0] num;
  logic               blend, neg;
  logic [59:0]        dvd_d;
  logic [35:0]        dvs_d;
  mpbu_pkg::item_t    item3_d;

  always_comb begin
    num   = $signed({2'b0, basep_q}) + $signed({prod_q[52], prod_q});
    blend = (region2_q == mpbu_pkg::REG_HIGH_BLEND) || (region2_q == mpbu_pkg::REG_LOW_BLEND);
    neg   = blend && (num <= 54'sd0);
    dvs_d = 36'd100000000;
    if (region2_q == mpbu_pkg::REG_HIGH_BLEND) begin
      dvd_d = {num[49:0], 10'b0} + 60'd33250000000;
      dvs_d = 36'd66500000000;
    end else if (region2_q == mpbu_pkg::REG_LOW_BLEND) begin
      dvd_d = {num[53:0], 6'b0} + 60'd50000000;
    end else begin
      dvd_d = {6'b0, num} + 60'd50000000;
    end
    item3_d    = item2_q;
    item3_d.ok = item2_q.ok & ~neg;
  end

  logic [59:0]     dvd_q;
  logic [35:0]     dvs_q;
  mpbu_pkg::item_t dsb_q [mpbu_pkg::DCells+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dvd_q    <= dvd_d;
      dvs_q    <= dvs_d;
      dsb_q[0] <= item3_d;
      for (int k = 1; k <= mpbu_pkg::DCells; k++) dsb_q[k] <= dsb_q[k-1];
    end
  end

  // coefficient divider row
  logic [35:0] dr_rem  [mpbu_pkg::DCells+1];
  logic [24:0] dr_low  [mpbu_pkg::DCells+1];
  logic [24:0] dr_quot [mpbu_pkg::DCells+1];
  logic [35:0] dr_div  [mpbu_pkg::DCells+1];

  assign dr_rem[0]  = {1'b0, dvd_q[59:25]};
  assign dr_low[0]  = dvd_q[24:0];
  assign dr_quot[0] = '0;
  assign dr_div[0]  = dvs_q;

  for (genvar g = 0; g < mpbu_pkg::DCells; g++) begin : g_dcell
    mpbu_div_cell #(.W(36), .LW(25), .QW(25)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (dr_rem[g]),
      .low_i  (dr_low[g]),
      .quot_i (dr_quot[g]),
      .div_i  (dr_div[g]),
      .rem_o  (dr_rem[g+1]),
      .low_o  (dr_low[g+1]),
      .quot_o (dr_quot[g+1]),
      .div_o  (dr_div[g+1])
    );
  end

  // coefficient, la maximum, divisor of the residue
  mpbu_pkg::item_t    it4;
  logic [24:0]        dq;
  logic [23:0]        dval;
  logic               ok4;
  logic [23:0]        la_max_q, la_max_d, la_carry;
  logic signed [25:0] dgap;

  always_comb begin
    it4      = dsb_q[mpbu_pkg::DCells];
    dq       = dr_quot[mpbu_pkg::DCells];
    dval     = '0;
    if (it4.ok) dval = dq[24] ? 24'hFFFFFF : dq[23:0];
    ok4      = it4.ok && (dval != 24'd0);
    la_carry = la_max_q;
    if (ok4 && (it4.element == 4'd0) && (dval > la_max_q)) la_carry = dval;
    la_max_d = it4.last_of_sweep ? 24'd0 : la_carry;
    dgap     = 26'sd8388608 - $signed({2'b0, dval});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_max_q <= '0;
    end else if (adv && vld_q[DPos]) begin
      la_max_q <= la_max_d;
    end
  end

  logic signed [41:0] den_q;
  logic [55:0]        ncd_q;
  mpbu_pkg::tail_t    tail4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= $signed({3'b0, dval, 15'b0}) + 42'(it4.melt_increment) * 42'(dgap);
      ncd_q <= 56'(it4.solid_conc) * 56'(dval);
      tail4_q.solid_conc <= it4.solid_conc;
      tail4_q.coef       <= dval;
      tail4_q.la_max     <= la_carry;
      tail4_q.ok         <= ok4;
      tail4_q.ovf_liq    <= 1'b0;
      tail4_q.ovf_sol    <= 1'b0;
    end
  end

  // setup of both quotient rows with overflow checks
  logic            ovf_l, ovf_s;
  logic [38:0]     shi;
  mpbu_pkg::tail_t tail5_d;

  always_comb begin
    ovf_l           = {9'b0, tail4_q.solid_conc} >= {tail4_q.coef, 17'b0};
    shi             = ncd_q[55:17];
    ovf_s           = shi >= den_q[38:0];
    tail5_d         = tail4_q;
    tail5_d.ovf_liq = ovf_l;
    tail5_d.ovf_sol = ovf_s;
  end

  logic [23:0]     lr_rem  [mpbu_pkg::LCells+1];
  logic [39:0]     lr_low  [mpbu_pkg::LCells+1];
  logic [39:0]     lr_quot [mpbu_pkg::LCells+1];
  logic [23:0]     lr_div  [mpbu_pkg::LCells+1];
  logic [38:0]     sr_rem  [mpbu_pkg::LCells+1];
  logic [39:0]     sr_low  [mpbu_pkg::LCells+1];
  logic [39:0]     sr_quot [mpbu_pkg::LCells+1];
  logic [38:0]     sr_div  [mpbu_pkg::LCells+1];
  mpbu_pkg::tail_t tsb_q   [mpbu_pkg::LCells+1];

  logic [23:0] lrem0_q;
  logic [39:0] llow0_q;
  logic [23:0] ldiv0_q;
  logic [38:0] srem0_q;
  logic [39:0] slow0_q;
  logic [38:0] sdiv0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lrem0_q  <= ovf_l ? 24'd0 : {9'b0, tail4_q.solid_conc[31:17]};
      llow0_q  <= {tail4_q.solid_conc[16:0], 23'b0};
      ldiv0_q  <= tail4_q.coef;
      srem0_q  <= ovf_s ? 39'd0 : shi;
      slow0_q  <= {ncd_q[16:0], 15'b0, 8'b0};
      sdiv0_q  <= den_q[38:0];
      tsb_q[0] <= tail5_d;
      for (int k = 1; k <= mpbu_pkg::LCells; k++) tsb_q[k] <= tsb_q[k-1];
    end
  end

  assign lr_rem[0]  = lrem0_q;
  assign lr_low[0]  = llow0_q;
  assign lr_quot[0] = '0;
  assign lr_div[0]  = ldiv0_q;
  assign sr_rem[0]  = srem0_q;
  assign sr_low[0]  = slow0_q;
  assign sr_quot[0] = '0;
  assign sr_div[0]  = sdiv0_q;

  for (genvar g = 0; g < mpbu_pkg::LCells; g++) begin : g_qcell
    mpbu_div_cell #(.W(24), .LW(40), .QW(40)) u_liq (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (lr_rem[g]),
      .low_i  (lr_low[g]),
      .quot_i (lr_quot[g]),
      .div_i  (lr_div[g]),
      .rem_o  (lr_rem[g+1]),
      .low_o  (lr_low[g+1]),
      .quot_o (lr_quot[g+1]),
      .div_o  (lr_div[g+1])
    );
    mpbu_div_cell #(.W(39), .LW(40), .QW(40)) u_sol (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (sr_rem[g]),
      .low_i  (sr_low[g]),
      .quot_i (sr_quot[g]),
      .div_i  (sr_div[g]),
      .rem_o  (sr_rem[g+1]),
      .low_o  (sr_low[g+1]),
      .quot_o (sr_quot[g+1]),
      .div_o  (sr_div[g+1])
    );
  end

  // output word
  mpbu_pkg::tail_t     tl;
  mpbu_pkg::out_word_t out_d;
  logic [39:0]         sq;

  always_comb begin
    tl                   = tsb_q[mpbu_pkg::LCells];
    sq                   = sr_quot[mpbu_pkg::LCells];
    out_d.liquid_conc    = '0;
    out_d.new_solid_conc = tl.solid_conc;
    out_d.partition_coef = tl.coef;
    out_d.max_la_coef    = tl.la_max;
    if (tl.ok) begin
      out_d.liquid_conc    = tl.ovf_liq ? 40'hFF_FFFF_FFFF : lr_quot[mpbu_pkg::LCells];
      out_d.new_solid_conc = tl.ovf_sol ? 32'hFFFF_FFFF : sq[39:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_word_o <= out_d;
  end

  a_zero_coef_no_liquid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.partition_coef != 24'd0 || out_word_o.liquid_conc == 40'd0))
    else $error("liquid word without a coefficient");

  a_empty_never_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

  a_sweep_clears_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[DPos] && it4.last_of_sweep) |=> (la_max_q == 24'd0))
    else $error("la maximum not cleared at sweep end");

endmodule
